### rtl/htwd_pkg.sv
// Package for the Huffman tree-walk decoder: field widths, the node-table
// entry layout, operation codes and the output word type.
// No dependencies.
package htwd_pkg;

  localparam int IDX_W          = 9;
  localparam int SYM_W          = 8;
  localparam int CNT_W          = 4;
  localparam int NODE_COUNT_DEF = 512;

  localparam logic [CNT_W-1:0] MAX_BITS = CNT_W'(8);

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  typedef struct packed {
    logic [IDX_W-1:0] left_child;
    logic [IDX_W-1:0] right_child;
    logic             has_left;
    logic             has_right;
    logic [SYM_W-1:0] leaf_symbol;
  } node_t;

  typedef struct packed {
    logic             valid;
    logic [SYM_W-1:0] symbol;
    logic             last_of_item;
  } out_push_t;

  function automatic logic is_leaf(input node_t n);
    return !n.has_left && !n.has_right;
  endfunction

endpackage

### rtl/htwd_in_if.sv
// Input channel of the Huffman tree-walk decoder: valid/ready plus one
// node-write or decode word. Depends on htwd_pkg.
interface htwd_in_if
  import htwd_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             op;
  logic [IDX_W-1:0] node_index;
  logic [IDX_W-1:0] left_child;
  logic [IDX_W-1:0] right_child;
  logic             has_left;
  logic             has_right;
  logic [SYM_W-1:0] leaf_symbol;
  logic [SYM_W-1:0] coded_byte;
  logic [CNT_W-1:0] valid_bits;

  modport source (
    output valid, op, node_index, left_child, right_child, has_left, has_right,
           leaf_symbol, coded_byte, valid_bits,
    input  ready
  );
  modport sink (
    input  valid, op, node_index, left_child, right_child, has_left, has_right,
           leaf_symbol, coded_byte, valid_bits,
    output ready
  );
endinterface

### rtl/htwd_out_if.sv
// Result channel of the Huffman tree-walk decoder: valid/ready plus one
// decoded symbol word. Depends on htwd_pkg.
interface htwd_out_if
  import htwd_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             last_of_item;

  modport source (output valid, symbol, last_of_item, input ready);
  modport sink   (input valid, symbol, last_of_item, output ready);
endinterface

### rtl/htwd_out_reg.sv
// Output register stage of the Huffman tree-walk decoder. Holds one result
// word so the walk can continue while the word waits. Depends on htwd_pkg.
module htwd_out_reg
  import htwd_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  out_push_t       push,
  output logic            slot_free,
  htwd_out_if.source      out_ch
);

  logic             valid_r;
  logic [SYM_W-1:0] symbol_r;
  logic             last_r;

  assign slot_free = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (slot_free) begin
      valid_r <= push.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && push.valid) begin
      symbol_r <= push.symbol;
      last_r   <= push.last_of_item;
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.symbol       = symbol_r;
  assign out_ch.last_of_item = last_r;

endmodule

### rtl/huffman_tree_walk_decoder.sv
// Huffman tree-walk decoder top level: node-table memory, walk control and
// root cache. Depends on htwd_pkg, htwd_in_if, htwd_out_if and htwd_out_reg.
//
//   Port group   Direction  Handshake     Word
//   in_ch        sink       valid/ready   node write (op 0) or coded byte (op 1)
//   out_ch       source     valid/ready   decoded symbol, last_of_item
//   cfg_we/data  input      write enable  root_index
//
// A decode word holds the input from its accept until the walk ends: the
// accept, then each valid bit in turn with at most one node-table read, then
// the resolve of the final read and the flush of the held symbol; the
// dependent read of the node table paces the walk.
// A node write or a root write passes through S_ROOT_RD and S_ROOT_WAIT, which
// reload the cached root node. After reset the root is loaded the same way.
// A full output register stalls the walk without losing the pending read.
module huffman_tree_walk_decoder
  import htwd_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_data,
  htwd_in_if.sink          in_ch,
  htwd_out_if.source       out_ch
);

  localparam int AW = $clog2(NODE_COUNT);

  typedef enum logic [3:0] {
    S_ROOT_RD   = 4'b0001,
    S_ROOT_WAIT = 4'b0010,
    S_IDLE      = 4'b0100,
    S_RUN       = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] root_r;
  node_t            root_entry_r;
  node_t            cur_r, cur_nxt;
  logic             pend_r, pend_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SYM_W-1:0] bits_r;
  logic             hold_v_r, hold_v_nxt;
  logic [SYM_W-1:0] hold_sym_r, hold_sym_nxt;

  node_t            mem [NODE_COUNT];
  node_t            rdata_r;
  logic             mem_we;
  logic [AW-1:0]    waddr;
  node_t            wdata;
  logic             rd_en;
  logic [AW-1:0]    raddr;

  logic             accept;
  logic             emit;
  logic             bit_avail;
  logic             code_bit;
  logic             child_has;
  logic [IDX_W-1:0] child_idx;
  logic             present;
  logic             done;
  logic             slot_free;
  logic             adv;
  out_push_t        push;
  node_t            cur;
  logic [CNT_W-1:0] vb_sat;

  assign in_ch.ready = (state_r == S_IDLE) && !cfg_we;
  assign accept      = in_ch.valid && in_ch.ready;

  assign mem_we = accept && (in_ch.op == OP_WRITE) && (32'(in_ch.node_index) < NODE_COUNT);
  assign waddr  = AW'(in_ch.node_index);
  assign wdata  = '{left_child:  in_ch.left_child,
                    right_child: in_ch.right_child,
                    has_left:    in_ch.has_left,
                    has_right:   in_ch.has_right,
                    leaf_symbol: in_ch.leaf_symbol};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  assign vb_sat = (in_ch.valid_bits > MAX_BITS) ? MAX_BITS : in_ch.valid_bits;

  // The current node is the fetched child unless that child was a leaf, in
  // which case the walk is back at the root.
  assign emit      = pend_r && is_leaf(rdata_r);
  assign cur       = pend_r ? (emit ? root_entry_r : rdata_r) : cur_r;
  assign bit_avail = (cnt_r != '0);
  assign code_bit  = bits_r[3'(cnt_r - CNT_W'(1))];
  assign child_has = code_bit ? cur.has_right : cur.has_left;
  assign child_idx = code_bit ? cur.right_child : cur.left_child;
  assign present   = child_has && (32'(child_idx) < NODE_COUNT);
  assign done      = !bit_avail;

  always_comb begin
    push.valid        = 1'b0;
    push.symbol       = hold_sym_r;
    push.last_of_item = 1'b0;
    if (state_r == S_RUN) begin
      if (emit && hold_v_r) begin
        push.valid = 1'b1;
      end else if (done && !pend_r && hold_v_r) begin
        push.valid        = 1'b1;
        push.last_of_item = 1'b1;
      end
    end
  end

  assign adv = !push.valid || slot_free;

  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    pend_nxt     = pend_r;
    cnt_nxt      = cnt_r;
    hold_v_nxt   = hold_v_r;
    hold_sym_nxt = hold_sym_r;
    rd_en        = 1'b0;
    raddr        = AW'(root_r);
    unique case (state_r)
      S_ROOT_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_ROOT_WAIT;
      end
      S_ROOT_WAIT: begin
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (in_ch.op == OP_WRITE) begin
            state_nxt = S_ROOT_RD;
          end else begin
            cnt_nxt   = vb_sat;
            state_nxt = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (adv) begin
          cur_nxt  = cur;
          pend_nxt = bit_avail && present;
          rd_en    = bit_avail && present;
          raddr    = AW'(child_idx);
          if (bit_avail) begin
            cnt_nxt = cnt_r - CNT_W'(1);
          end
          if (emit) begin
            hold_v_nxt   = 1'b1;
            hold_sym_nxt = rdata_r.leaf_symbol;
          end else if (done && !pend_r) begin
            hold_v_nxt = 1'b0;
          end
          if (done && !pend_r) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_ROOT_RD;
      end
    endcase
    if (cfg_we) begin
      state_nxt  = S_ROOT_RD;
      pend_nxt   = 1'b0;
      hold_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_ROOT_RD;
      root_r   <= '0;
      pend_r   <= 1'b0;
      cnt_r    <= '0;
      hold_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pend_r   <= pend_nxt;
      cnt_r    <= cnt_nxt;
      hold_v_r <= hold_v_nxt;
      if (cfg_we) begin
        root_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    hold_sym_r <= hold_sym_nxt;
    if (accept && in_ch.op == OP_DECODE) begin
      bits_r <= in_ch.coded_byte;
    end
    if (state_r == S_ROOT_WAIT) begin
      root_entry_r <= (32'(root_r) < NODE_COUNT) ? rdata_r : '0;
      cur_r        <= (32'(root_r) < NODE_COUNT) ? rdata_r : '0;
    end else begin
      cur_r <= cur_nxt;
    end
  end

  htwd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .slot_free (slot_free),
    .out_ch    (out_ch)
  );

  a_pend_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> state_r == S_RUN)
    else $error("node read pending outside a decode walk");

  a_hold_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !hold_v_r)
    else $error("held symbol left over after a decode word");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_BITS)
    else $error("bit count above eight");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN && !adv && !cfg_we) |=> $stable(cnt_r) && $stable(pend_r))
    else $error("walk advanced while the output was blocked");

  a_write_reloads_root: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.op == OP_WRITE) |=> state_r == S_ROOT_RD)
    else $error("node write did not return the walk to the root");

endmodule
